FILE: sv/ansi_escape_sequence_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ANSI escape sequence parser
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_SEQUENCE_PARSER_CORE_ASSERT_SVH
`define ANSI_ESCAPE_SEQUENCE_PARSER_CORE_ASSERT_SVH

// Check that a property holds at every clock edge outside reset.
`define AESP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define AESP_ASSERT_NEVER(name, cond, msg) \
  `AESP_ASSERT(name, !(cond), msg)

`endif

FILE: sv/aesp_pkg.sv
// ----------------------------------------------------------------------------
// aesp_pkg
// Types and constants shared by the ANSI escape sequence parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package aesp_pkg;

  localparam int unsigned MaxParams    = 8;
  localparam int unsigned MaxDigits    = 6;
  localparam int unsigned NumOutParams = 8;
  localparam int unsigned ParamW       = 16;
  localparam int unsigned ValueW       = 20;
  localparam int unsigned ParamCntW    = $clog2(MaxParams + 1);
  localparam int unsigned ParamIdxW    = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int unsigned DigitCntW    = $clog2(MaxDigits + 1);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChCsi   = 8'h5B;
  localparam logic [7:0] ChOsc   = 8'h5D;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeEsc,
    ModeCsi,
    ModeOsc
  } mode_e;

  typedef enum logic [1:0] {
    EvPrint,
    EvNewline,
    EvCr,
    EvCsi
  } event_kind_e;

  typedef logic [ParamW-1:0] param_t;

endpackage

`default_nettype wire

FILE: sv/aesp_if.sv
// ----------------------------------------------------------------------------
// aesp_byte_if / aesp_event_if
// Valid/ready channels for input bytes and parser events.
// ----------------------------------------------------------------------------
`default_nettype none

interface aesp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface aesp_event_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           event_kind;
  logic [7:0]           event_byte;
  aesp_pkg::param_t     param0;
  aesp_pkg::param_t     param1;
  aesp_pkg::param_t     param2;
  aesp_pkg::param_t     param3;
  aesp_pkg::param_t     param4;
  aesp_pkg::param_t     param5;
  aesp_pkg::param_t     param6;
  aesp_pkg::param_t     param7;

  modport source (
    output valid, output event_kind, output event_byte,
    output param0, output param1, output param2, output param3,
    output param4, output param5, output param6, output param7,
    input ready
  );
  modport sink (
    input valid, input event_kind, input event_byte,
    input param0, input param1, input param2, input param3,
    input param4, input param5, input param6, input param7,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/ansi_escape_sequence_parser_core.sv
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser_core
// VT100/ANSI byte stream parser producing print, newline, CR and CSI events.
// ----------------------------------------------------------------------------
// Takes one byte per clock while in_i.ready is high and produces at most one
// event per byte, in the cycle after the byte transfer, from a single output
// register. The parse state (mode, digit accumulator, parameter store) updates
// in the same cycle the byte is taken, so bytes stream back to back at one per
// cycle while no event stalls; in_i.ready drops only while a finished event
// waits on out_o. After ESC ] every later byte is swallowed until reset.
`default_nettype none

module ansi_escape_sequence_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  aesp_byte_if.sink           in_i,
  aesp_event_if.source        out_o
);

  aesp_pkg::mode_e                         mode_q, mode_d;
  logic [aesp_pkg::DigitCntW-1:0]          dcnt_q, dcnt_d;
  logic [aesp_pkg::ValueW-1:0]             dval_q, dval_d;
  logic [aesp_pkg::ParamCntW-1:0]          pcnt_q, pcnt_d;
  aesp_pkg::param_t                        store_q [aesp_pkg::MaxParams];
  aesp_pkg::param_t                        store_d [aesp_pkg::MaxParams];

  logic                                    ov_q;
  aesp_pkg::event_kind_e                   kind_q, kind_d;
  logic [7:0]                              byte_q;
  aesp_pkg::param_t                        evp_q [aesp_pkg::NumOutParams];
  aesp_pkg::param_t                        evp_d [aesp_pkg::NumOutParams];
  aesp_pkg::param_t                        csi_p [aesp_pkg::NumOutParams];

  logic                                    accept;
  logic                                    emit;
  logic [7:0]                              c;
  logic                                    is_digit;
  logic                                    is_sep;
  logic                                    store_hit;
  logic [aesp_pkg::ParamCntW-1:0]          pcnt_st;
  logic [aesp_pkg::ValueW-1:0]             dval_acc;

  assign c         = in_i.byte_in;
  assign in_i.ready = !ov_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;

  assign is_digit  = (c >= aesp_pkg::ChZero) && (c <= aesp_pkg::ChNine);
  assign is_sep    = (c == aesp_pkg::ChComma) || (c == aesp_pkg::ChSemi) ||
                     (c == aesp_pkg::ChNul);
  assign store_hit = pcnt_q < aesp_pkg::ParamCntW'(aesp_pkg::MaxParams);
  assign pcnt_st   = store_hit ? pcnt_q + aesp_pkg::ParamCntW'(1) : pcnt_q;
  assign dval_acc  = {dval_q[aesp_pkg::ValueW-4:0], 3'b000} +
                     {dval_q[aesp_pkg::ValueW-2:0], 1'b0} +
                     aesp_pkg::ValueW'(c[3:0]);

  always_comb begin
    mode_d = mode_q;
    dcnt_d = dcnt_q;
    dval_d = dval_q;
    pcnt_d = pcnt_q;
    store_d = store_q;
    emit   = 1'b0;
    kind_d = aesp_pkg::EvPrint;
    unique case (mode_q)
      aesp_pkg::ModeIdle: begin
        if (c == aesp_pkg::ChEsc) begin
          mode_d = aesp_pkg::ModeEsc;
        end else begin
          emit = 1'b1;
          if (c == aesp_pkg::ChLf) begin
            kind_d = aesp_pkg::EvNewline;
          end else if (c == aesp_pkg::ChCr) begin
            kind_d = aesp_pkg::EvCr;
          end
        end
      end
      aesp_pkg::ModeEsc: begin
        if (c == aesp_pkg::ChCsi) begin
          mode_d = aesp_pkg::ModeCsi;
        end else if (c == aesp_pkg::ChOsc) begin
          mode_d = aesp_pkg::ModeOsc;
        end else begin
          mode_d = aesp_pkg::ModeIdle;
        end
      end
      aesp_pkg::ModeCsi: begin
        if (is_digit) begin
          if (dcnt_q < aesp_pkg::DigitCntW'(aesp_pkg::MaxDigits)) begin
            dval_d = dval_acc;
            dcnt_d = dcnt_q + aesp_pkg::DigitCntW'(1);
          end else begin
            // abort the sequence
            dval_d = '0;
            dcnt_d = '0;
            pcnt_d = '0;
            mode_d = aesp_pkg::ModeIdle;
          end
        end else begin
          dval_d = '0;
          dcnt_d = '0;
          pcnt_d = pcnt_st;
          if (store_hit) begin
            store_d[pcnt_q[aesp_pkg::ParamIdxW-1:0]] = dval_q[aesp_pkg::ParamW-1:0];
          end
          if (!is_sep) begin
            for (int i = 0; i < aesp_pkg::MaxParams; i++) begin
              if (aesp_pkg::ParamCntW'(i) >= pcnt_st) begin
                store_d[i] = '0;
              end
            end
            pcnt_d = '0;
            mode_d = aesp_pkg::ModeIdle;
            emit   = 1'b1;
            kind_d = aesp_pkg::EvCsi;
          end
        end
      end
      aesp_pkg::ModeOsc: begin
        mode_d = aesp_pkg::ModeOsc;
      end
      default: begin
        mode_d = aesp_pkg::ModeIdle;
      end
    endcase
  end

  for (genvar j = 0; j < aesp_pkg::NumOutParams; j++) begin : g_outp
    if (j < aesp_pkg::MaxParams) begin : g_used
      assign csi_p[j] = store_d[j];
    end else begin : g_unused
      assign csi_p[j] = '0;
    end
    assign evp_d[j] = (kind_d == aesp_pkg::EvCsi) ? csi_p[j] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= aesp_pkg::ModeIdle;
      dcnt_q <= '0;
      dval_q <= '0;
      pcnt_q <= '0;
      for (int i = 0; i < aesp_pkg::MaxParams; i++) begin
        store_q[i] <= '0;
      end
      ov_q   <= 1'b0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        dcnt_q  <= dcnt_d;
        dval_q  <= dval_d;
        pcnt_q  <= pcnt_d;
        store_q <= store_d;
        ov_q    <= emit;
      end else if (out_o.ready) begin
        ov_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q <= kind_d;
      byte_q <= c;
      evp_q  <= evp_d;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.event_kind = kind_q;
  assign out_o.event_byte = byte_q;
  assign out_o.param0     = evp_q[0];
  assign out_o.param1     = evp_q[1];
  assign out_o.param2     = evp_q[2];
  assign out_o.param3     = evp_q[3];
  assign out_o.param4     = evp_q[4];
  assign out_o.param5     = evp_q[5];
  assign out_o.param6     = evp_q[6];
  assign out_o.param7     = evp_q[7];

endmodule

`default_nettype wire

FILE: sv/aesp_checker.sv
// ----------------------------------------------------------------------------
// aesp_checker
// Port-level assertions for the ANSI escape sequence parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ansi_escape_sequence_parser_core_assert.svh"

module aesp_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [1:0]       out_kind_i,
  input  logic [7:0]       out_byte_i,
  input  aesp_pkg::param_t out_p0_i,
  input  aesp_pkg::param_t out_p1_i,
  input  aesp_pkg::param_t out_p2_i,
  input  aesp_pkg::param_t out_p3_i,
  input  aesp_pkg::param_t out_p4_i,
  input  aesp_pkg::param_t out_p5_i,
  input  aesp_pkg::param_t out_p6_i,
  input  aesp_pkg::param_t out_p7_i
);

  logic                            out_stall;
  logic                            is_csi;
  logic                            is_plain;
  logic                            params_zero;
  logic                            csi_bad_final;
  logic                            print_esc;
  logic                            in_xfer;
  logic [8*aesp_pkg::ParamW+9:0]   out_word;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign is_csi      = out_valid_i && (out_kind_i == aesp_pkg::EvCsi);
  assign is_plain    = out_valid_i && (out_kind_i != aesp_pkg::EvCsi);
  assign in_xfer     = in_valid_i && in_ready_i;
  assign out_word    = {out_kind_i, out_byte_i, out_p0_i, out_p1_i, out_p2_i, out_p3_i,
                        out_p4_i, out_p5_i, out_p6_i, out_p7_i};
  assign params_zero = (out_p0_i == '0) && (out_p1_i == '0) && (out_p2_i == '0) &&
                       (out_p3_i == '0) && (out_p4_i == '0) && (out_p5_i == '0) &&
                       (out_p6_i == '0) && (out_p7_i == '0);
  assign csi_bad_final = ((out_byte_i >= aesp_pkg::ChZero) &&
                          (out_byte_i <= aesp_pkg::ChNine)) ||
                         (out_byte_i == aesp_pkg::ChComma) ||
                         (out_byte_i == aesp_pkg::ChSemi) ||
                         (out_byte_i == aesp_pkg::ChNul);
  assign print_esc   = out_valid_i && (out_kind_i == aesp_pkg::EvPrint) &&
                       (out_byte_i == aesp_pkg::ChEsc);

  `AESP_ASSERT(a_hold, out_stall |=> out_valid_i && $stable(out_word), "event changed in stall")
  `AESP_ASSERT_NEVER(a_stall_no_in, out_stall && in_xfer, "byte taken while event stalled")
  `AESP_ASSERT(a_plain_zero, is_plain |-> params_zero, "plain event carries params")
  `AESP_ASSERT_NEVER(a_csi_final, is_csi && csi_bad_final, "bad CSI final byte")
  `AESP_ASSERT_NEVER(a_print_esc, print_esc, "ESC printed")

endmodule

bind ansi_escape_sequence_parser_core aesp_checker u_aesp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.event_kind),
  .out_byte_i  (out_o.event_byte),
  .out_p0_i    (out_o.param0),
  .out_p1_i    (out_o.param1),
  .out_p2_i    (out_o.param2),
  .out_p3_i    (out_o.param3),
  .out_p4_i    (out_o.param4),
  .out_p5_i    (out_o.param5),
  .out_p6_i    (out_o.param6),
  .out_p7_i    (out_o.param7)
);

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the ANSI escape sequence parser core.
// ----------------------------------------------------------------------------
// Feeds directed and random terminal byte streams through the byte channel
// with random gaps on both sides. Each transferred byte runs through a local
// parser that predicts the event it causes. Every event transfer is checked
// field by field against the oldest prediction. The stream ends by entering
// OSC mode, after which no further event may appear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NumItems    = 2000;
  localparam int unsigned StallMax    = 19;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned PrintMax    = 200;

  typedef struct packed {
    aesp_pkg::mode_e                              mode;
    logic [aesp_pkg::DigitCntW-1:0]               ndig;
    logic [aesp_pkg::ValueW-1:0]                  acc;
    logic [aesp_pkg::ParamCntW-1:0]               npar;
    aesp_pkg::param_t [aesp_pkg::MaxParams-1:0]   store;
  } parser_t;

  typedef struct packed {
    aesp_pkg::event_kind_e                          kind;
    logic [7:0]                                     ch;
    aesp_pkg::param_t [aesp_pkg::NumOutParams-1:0]  prm;
  } term_event_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       drain;
    logic [4:0] gap;
  } byte_item_t;

  logic clk;
  logic rst_n;

  aesp_byte_if  byte_ch();
  aesp_event_if event_ch();

  ansi_escape_sequence_parser_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (event_ch)
  );

  parser_t      model_state;
  parser_t      gen_state;
  term_event_t  pending_events[$];
  byte_item_t   byte_queue[$];
  byte_item_t   next_item;
  term_event_t  predicted_ev;
  term_event_t  got_ev;
  term_event_t  exp_ev;

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned item_count  = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  bit          in_xfer     = 1'b0;
  bit          out_xfer    = 1'b0;
  bit          send_burst  = 1'b0;
  bit          recv_burst  = 1'b0;
  bit          osc_allowed = 1'b0;

  function automatic logic parse_byte(inout parser_t st, input logic [7:0] c,
                                      output term_event_t ev);
    logic emit;
    emit = 1'b0;
    ev   = '0;
    case (st.mode)
      aesp_pkg::ModeIdle: begin
        if (c == aesp_pkg::ChEsc) begin
          st.mode = aesp_pkg::ModeEsc;
        end else begin
          emit  = 1'b1;
          ev.ch = c;
          if (c == aesp_pkg::ChLf) ev.kind = aesp_pkg::EvNewline;
          else if (c == aesp_pkg::ChCr) ev.kind = aesp_pkg::EvCr;
          else ev.kind = aesp_pkg::EvPrint;
        end
      end
      aesp_pkg::ModeEsc: begin
        if (c == aesp_pkg::ChCsi) st.mode = aesp_pkg::ModeCsi;
        else if (c == aesp_pkg::ChOsc) st.mode = aesp_pkg::ModeOsc;
        else st.mode = aesp_pkg::ModeIdle;
      end
      aesp_pkg::ModeCsi: begin
        if (c >= aesp_pkg::ChZero && c <= aesp_pkg::ChNine) begin
          if (st.ndig < aesp_pkg::MaxDigits) begin
            st.acc  = aesp_pkg::ValueW'(st.acc * 10 +
                                        aesp_pkg::ValueW'(c - aesp_pkg::ChZero));
            st.ndig = st.ndig + 1'b1;
          end else begin
            // abort: too many digits
            st.acc  = '0;
            st.ndig = '0;
            st.npar = '0;
            st.mode = aesp_pkg::ModeIdle;
          end
        end else begin
          if (st.npar < aesp_pkg::MaxParams) begin
            st.store[st.npar[aesp_pkg::ParamIdxW-1:0]] = st.acc[aesp_pkg::ParamW-1:0];
            st.npar = st.npar + 1'b1;
          end
          st.acc  = '0;
          st.ndig = '0;
          if (c != aesp_pkg::ChComma && c != aesp_pkg::ChSemi && c != aesp_pkg::ChNul) begin
            for (int i = 0; i < aesp_pkg::MaxParams; i++) begin
              if (i >= st.npar) st.store[i] = '0;
            end
            st.npar = '0;
            st.mode = aesp_pkg::ModeIdle;
            emit    = 1'b1;
            ev.kind = aesp_pkg::EvCsi;
            ev.ch   = c;
            for (int i = 0; i < aesp_pkg::NumOutParams; i++) begin
              if (i < aesp_pkg::MaxParams) ev.prm[i] = st.store[i];
            end
          end
        end
      end
      default: ;
    endcase
    return emit;
  endfunction

  task automatic push_byte(input logic [7:0] c, input logic drain);
    byte_item_t  it;
    term_event_t ev;
    // hold OSC back until the tail of the stream
    if (gen_state.mode == aesp_pkg::ModeEsc && c == aesp_pkg::ChOsc && !osc_allowed)
      c = aesp_pkg::ChCsi;
    void'(parse_byte(gen_state, c, ev));
    if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
    it.ch    = c;
    it.drain = drain;
    it.gap   = send_burst ? 5'd0 : 5'($urandom_range(0, StallMax));
    byte_queue.push_back(it);
    item_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic report_error(input string msg);
    if (error_count < PrintMax) $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!byte_ch.valid || in_xfer) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_ch.valid <= 1'b0;
        end else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].drain && pending_events.size() > 0)) begin
          next_item = byte_queue.pop_front();
          byte_ch.valid   <= 1'b1;
          byte_ch.byte_in <= next_item.ch;
          gap_left = next_item.gap;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_xfer) begin
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, StallMax);
      end
      if (stall_left > 0) begin
        stall_left--;
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_xfer  <= rst_n && byte_ch.valid && byte_ch.ready;
    out_xfer <= rst_n && event_ch.valid && event_ch.ready;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (parse_byte(model_state, byte_ch.byte_in, predicted_ev)) begin
          pending_events.push_back(predicted_ev);
        end
      end
      if (event_ch.valid && event_ch.ready) begin
        got_ev.kind   = aesp_pkg::event_kind_e'(event_ch.event_kind);
        got_ev.ch     = event_ch.event_byte;
        got_ev.prm[0] = event_ch.param0;
        got_ev.prm[1] = event_ch.param1;
        got_ev.prm[2] = event_ch.param2;
        got_ev.prm[3] = event_ch.param3;
        got_ev.prm[4] = event_ch.param4;
        got_ev.prm[5] = event_ch.param5;
        got_ev.prm[6] = event_ch.param6;
        got_ev.prm[7] = event_ch.param7;
        if (pending_events.size() == 0) begin
          report_error($sformatf("event kind %0d byte %02h with none expected",
                                 event_ch.event_kind, event_ch.event_byte));
        end else begin
          exp_ev = pending_events.pop_front();
          if (got_ev.kind != exp_ev.kind)
            report_error($sformatf("event_kind got %0d, expected %0d",
                                   got_ev.kind, exp_ev.kind));
          if (got_ev.ch != exp_ev.ch)
            report_error($sformatf("event_byte got %02h, expected %02h",
                                   got_ev.ch, exp_ev.ch));
          for (int i = 0; i < aesp_pkg::NumOutParams; i++) begin
            if (got_ev.prm[i] != exp_ev.prm[i])
              report_error($sformatf("param%0d got %0d, expected %0d",
                                     i, got_ev.prm[i], exp_ev.prm[i]));
          end
        end
      end
      if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int          sel;
    int          fields;
    int          digits;
    logic [7:0]  fin;

    rst_n           = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    event_ch.ready  = 1'b0;
    gen_state       = '0;
    model_state     = '0;

    // print extremes, newline, carriage return
    push_byte(aesp_pkg::ChNul, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(aesp_pkg::ChLf, 1'b0);
    push_byte(aesp_pkg::ChCr, 1'b0);
    // escape followed by an ordinary byte
    push_byte(aesp_pkg::ChEsc, 1'b0);
    push_text("q");
    // command with no parameters
    push_byte(aesp_pkg::ChEsc, 1'b0);
    push_text("[m");
    // widest value, every separator, empty parameters
    push_byte(aesp_pkg::ChEsc, 1'b0);
    push_text("[999999;,");
    push_byte(aesp_pkg::ChNul, 1'b0);
    push_text("H");
    // digit overflow aborts, then plain print after an idle wait
    push_byte(aesp_pkg::ChEsc, 1'b0);
    push_text("[1234567");
    push_byte("Z", 1'b1);

    while (item_count < NumItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        push_byte(aesp_pkg::ChEsc, $urandom_range(0, 299) == 0);
        push_byte(aesp_pkg::ChCsi, 1'b0);
        fields = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        for (int f = 0; f < fields; f++) begin
          if (f > 0) begin
            case ($urandom_range(0, 2))
              0: push_byte(aesp_pkg::ChComma, 1'b0);
              1: push_byte(aesp_pkg::ChSemi, 1'b0);
              default: push_byte(aesp_pkg::ChNul, 1'b0);
            endcase
          end
          digits = ($urandom_range(0, 49) == 0) ? aesp_pkg::MaxDigits + 1 :
                                                  $urandom_range(0, aesp_pkg::MaxDigits);
          for (int d = 0; d < digits; d++)
            push_byte(aesp_pkg::ChZero + 8'($urandom_range(0, 9)), 1'b0);
        end
        if ($urandom_range(0, 4) != 0) begin
          fin = 8'($urandom_range(8'h40, 8'h7E));
        end else begin
          fin = 8'($urandom_range(0, 255));
          while ((fin >= aesp_pkg::ChZero && fin <= aesp_pkg::ChNine) ||
                 fin == aesp_pkg::ChComma || fin == aesp_pkg::ChSemi ||
                 fin == aesp_pkg::ChNul)
            fin = 8'($urandom_range(0, 255));
        end
        push_byte(fin, 1'b0);
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 93) begin
        push_byte(aesp_pkg::ChEsc, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_byte(aesp_pkg::ChEsc, 1'b0);
        push_byte(aesp_pkg::ChCsi, 1'b0);
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    // return to idle, then enter OSC; everything after it is swallowed
    while (gen_state.mode != aesp_pkg::ModeIdle) push_text("m");
    osc_allowed = 1'b1;
    push_byte(aesp_pkg::ChEsc, 1'b1);
    push_byte(aesp_pkg::ChOsc, 1'b0);
    repeat (16) push_byte(8'($urandom_range(0, 255)), 1'b0);
    push_byte(aesp_pkg::ChEsc, 1'b0);
    push_text("[1mA");
    push_byte(aesp_pkg::ChLf, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (byte_queue.size() != 0 || byte_ch.valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: ansi_escape_sequence_parser_core.f
+incdir+sv
sv/aesp_pkg.sv
sv/aesp_if.sv
sv/ansi_escape_sequence_parser_core.sv
sv/aesp_checker.sv
test/tb_top.sv
